>>> rtl/core/mavg_pkg.sv
// Shared constants and types for the multichannel ADC moving average unit.
// No dependencies; used by every module under rtl/core.
package mavg_pkg;

   // Block geometry. HISTORY_DEPTH is a power of two (the average is a shift).
   localparam int CHANNELS      = 6;
   localparam int HISTORY_DEPTH = 16;

   // Field widths fixed by the interface
   localparam int SAMPLE_W  = 10;
   localparam int REQ_CAP_W = 2;
   localparam int OUT_CH_W  = 3;
   localparam int CAP_SLOT_W = 2;

   // Derived widths
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SL_W   = $clog2(HISTORY_DEPTH);
   localparam int ENTRIES = CHANNELS * HISTORY_DEPTH;
   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int SUM_W  = SAMPLE_W + SL_W;

   localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CHANNELS - 1);
   localparam logic [SL_W-1:0]   SL_LAST   = SL_W'(HISTORY_DEPTH - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(ENTRIES - 1);

   // Averages are reported whenever the slot index is a multiple of four
   localparam logic [SL_W-1:0] AVG_MASK = SL_W'(3);

   // Capture request codes
   localparam logic [REQ_CAP_W-1:0] CAP_NONE = 2'd0;

   // Output queue
   localparam int OQ_DEPTH = 3;
   localparam int OQ_PTR_W = 2;
   localparam int OQ_CNT_W = 2;

   // Item in the update stage
   typedef struct packed {
      logic [CH_W-1:0]       ch;
      logic [CH_W-1:0]       nxt_ch;
      logic [ADDR_W-1:0]     addr;
      logic [SAMPLE_W-1:0]   smp;
      logic                  avg_ok;
      logic                  cap_valid;
      logic [CAP_SLOT_W-1:0] cap_slot;
   } stage_type;

   // Result item
   typedef struct packed {
      logic [OUT_CH_W-1:0]   sampled_channel;
      logic                  average_valid;
      logic [OUT_CH_W-1:0]   average_channel;
      logic [SAMPLE_W-1:0]   average_value;
      logic                  capture_valid;
      logic [CAP_SLOT_W-1:0] capture_slot;
   } rsp_type;

endpackage

>>> rtl/core/mavg_hist_ram.sv
// History ring store: one write port, one registered read port.
// Depends on mavg_pkg. Entries read as zero until the first full lap is done.
module mavg_hist_ram (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [mavg_pkg::ADDR_W-1:0]    rd_addr,
   output logic [mavg_pkg::SAMPLE_W-1:0]  rd_data,
   input  logic                           wr_en,
   input  logic [mavg_pkg::ADDR_W-1:0]    wr_addr,
   input  logic [mavg_pkg::SAMPLE_W-1:0]  wr_data
);

   logic [mavg_pkg::SAMPLE_W-1:0] mem_ff [mavg_pkg::ENTRIES];
   logic [mavg_pkg::SAMPLE_W-1:0] q_ff;
   logic                          q_ok_ff;
   logic                          filled_ff;
   logic                          filled_in;

   // Entries are visited in a fixed order, so the last address marks the
   // end of the first lap; before that every read sees the reset value.
   always_comb begin
      filled_in = filled_ff;
      if (rd_en && (rd_addr == mavg_pkg::ADDR_LAST)) begin
         filled_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
      end else begin
         filled_ff <= filled_in;
      end
   end

   // Memory array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff    <= mem_ff[rd_addr];
         q_ok_ff <= filled_ff;
      end
   end

   assign rd_data = q_ok_ff ? q_ff : '0;

endmodule

>>> rtl/core/mavg_sum_ram.sv
// Per-channel running sums: one write port, two registered read ports.
// Depends on mavg_pkg. Forwards a write that lands on the edge of a read.
module mavg_sum_ram (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [mavg_pkg::CH_W-1:0]    rd_addr_a,
   input  logic [mavg_pkg::CH_W-1:0]    rd_addr_b,
   output logic [mavg_pkg::SUM_W-1:0]   rd_data_a,
   output logic [mavg_pkg::SUM_W-1:0]   rd_data_b,
   input  logic                         wr_en,
   input  logic [mavg_pkg::CH_W-1:0]    wr_addr,
   input  logic [mavg_pkg::SUM_W-1:0]   wr_data
);

   logic [mavg_pkg::SUM_W-1:0] mem_ff [mavg_pkg::CHANNELS];
   logic [mavg_pkg::CHANNELS-1:0] vld_ff;
   logic [mavg_pkg::SUM_W-1:0] q_a_ff, q_b_ff;
   logic                       ok_a_ff, ok_b_ff;
   logic [mavg_pkg::CH_W-1:0]  raddr_a_ff, raddr_b_ff;
   logic                       fwd_vld_ff;
   logic [mavg_pkg::CH_W-1:0]  fwd_addr_ff;
   logic [mavg_pkg::SUM_W-1:0] fwd_data_ff;

   // Valid bits: a sum never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         fwd_vld_ff <= wr_en;
      end
   end

   // Memory array and read registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_a_ff     <= mem_ff[rd_addr_a];
         q_b_ff     <= mem_ff[rd_addr_b];
         ok_a_ff    <= vld_ff[rd_addr_a];
         ok_b_ff    <= vld_ff[rd_addr_b];
         raddr_a_ff <= rd_addr_a;
         raddr_b_ff <= rd_addr_b;
      end
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
   end

   // Read data: a write on the read edge wins over the stale array value
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == raddr_a_ff)) begin
         rd_data_a = fwd_data_ff;
      end else begin
         rd_data_a = ok_a_ff ? q_a_ff : '0;
      end
      if (fwd_vld_ff && (fwd_addr_ff == raddr_b_ff)) begin
         rd_data_b = fwd_data_ff;
      end else begin
         rd_data_b = ok_b_ff ? q_b_ff : '0;
      end
   end

endmodule

>>> rtl/core/mavg_outq.sv
// Three-entry result queue that decouples the update stage from rsp_stall.
// Depends on mavg_pkg.
module mavg_outq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  mavg_pkg::rsp_type              push_data,
   input  logic                           pop,
   output logic                           out_valid,
   output mavg_pkg::rsp_type              out_data,
   output logic [mavg_pkg::OQ_CNT_W-1:0]  count
);

   mavg_pkg::rsp_type                q_ff [mavg_pkg::OQ_DEPTH];
   logic [mavg_pkg::OQ_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mavg_pkg::OQ_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mavg_pkg::OQ_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                             do_pop;

   assign out_valid = (cnt_ff != '0);
   assign out_data  = q_ff[rd_ptr_ff];
   assign count     = cnt_ff;
   assign do_pop    = pop && out_valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mavg_pkg::OQ_PTR_W'(mavg_pkg::OQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mavg_pkg::OQ_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mavg_pkg::OQ_PTR_W'(mavg_pkg::OQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mavg_pkg::OQ_PTR_W'(1);
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + mavg_pkg::OQ_CNT_W'(1);
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - mavg_pkg::OQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   // No push into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != mavg_pkg::OQ_CNT_W'(mavg_pkg::OQ_DEPTH)) || do_pop)
      else $error("result queue overflow");

endmodule

>>> rtl/core/multichannel_adc_moving_average_unit.sv
// Multichannel ADC moving average unit, top level.
// Depends on mavg_pkg, mavg_hist_ram, mavg_sum_ram and mavg_outq.
//
// Samples arrive for channels in round-robin order; each one replaces the
// oldest entry of its channel's 16-deep history and updates that channel's
// running sum. Whenever the slot index is a multiple of four after the
// advance, the transfer also carries the average of the channel now current.
// The block takes one transfer per clock unless stalled: an accepted sample
// issues its reads of the history and sum memories at once, the next cycle
// does the read-modify-write and pushes the result into a three-entry
// queue, from which it is offered on the response side. The request side
// stalls only when that queue and the update stage hold three results. No
// clearing pass is run after reset: history reads as zero until every entry
// has been written once, and sums carry per-channel valid bits.
module multichannel_adc_moving_average_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mavg_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic [mavg_pkg::REQ_CAP_W-1:0]    req_capture_request,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mavg_pkg::OUT_CH_W-1:0]     rsp_sampled_channel,
   output logic                              rsp_average_valid,
   output logic [mavg_pkg::OUT_CH_W-1:0]     rsp_average_channel,
   output logic [mavg_pkg::SAMPLE_W-1:0]     rsp_average_value,
   output logic                              rsp_capture_valid,
   output logic [mavg_pkg::CAP_SLOT_W-1:0]   rsp_capture_slot
);

   logic                           req_xfer;
   logic [mavg_pkg::CH_W-1:0]      ch_ff, ch_in;
   logic [mavg_pkg::SL_W-1:0]      sl_ff, sl_in;
   logic [mavg_pkg::ADDR_W-1:0]    rd_addr;
   mavg_pkg::stage_type            s1_ff, s1_in;
   logic                           s1_valid_ff;
   logic [mavg_pkg::SAMPLE_W-1:0]  old_smp;
   logic [mavg_pkg::SUM_W-1:0]     sum_cur, sum_nxt, new_sum, avg_src;
   mavg_pkg::rsp_type              rsp_item, oq_data;
   logic [mavg_pkg::OQ_CNT_W-1:0]  oq_count;
   logic [mavg_pkg::OQ_CNT_W:0]    in_flight;

   // Flow control: queue entries plus the item in the update stage
   assign in_flight = {1'b0, oq_count} + {{mavg_pkg::OQ_CNT_W{1'b0}}, s1_valid_ff};
   assign req_stall = (in_flight >= (mavg_pkg::OQ_CNT_W + 1)'(mavg_pkg::OQ_DEPTH));
   assign req_xfer  = req_valid && !req_stall;

   // Round-robin channel and slot advance
   always_comb begin
      if (ch_ff == mavg_pkg::CH_LAST) begin
         ch_in = '0;
         sl_in = (sl_ff == mavg_pkg::SL_LAST) ? '0 : sl_ff + mavg_pkg::SL_W'(1);
      end else begin
         ch_in = ch_ff + mavg_pkg::CH_W'(1);
         sl_in = sl_ff;
      end
   end

   assign rd_addr = mavg_pkg::ADDR_W'({ch_ff, sl_ff});

   // Stage entry
   always_comb begin
      s1_in.ch        = ch_ff;
      s1_in.nxt_ch    = ch_in;
      s1_in.addr      = rd_addr;
      s1_in.smp       = req_sample;
      s1_in.avg_ok    = ((sl_in & mavg_pkg::AVG_MASK) == '0);
      s1_in.cap_valid = (req_capture_request != mavg_pkg::CAP_NONE);
      s1_in.cap_slot  = s1_in.cap_valid ?
                        mavg_pkg::CAP_SLOT_W'(req_capture_request - 2'd1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff       <= '0;
         sl_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
         if (req_xfer) begin
            ch_ff <= ch_in;
            sl_ff <= sl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ff <= s1_in;
      end
   end

   // State memories
   mavg_hist_ram u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .rd_data (old_smp),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ff.addr),
      .wr_data (s1_ff.smp)
   );

   mavg_sum_ram u_sums (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_xfer),
      .rd_addr_a (ch_ff),
      .rd_addr_b (ch_in),
      .rd_data_a (sum_cur),
      .rd_data_b (sum_nxt),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_ff.ch),
      .wr_data   (new_sum)
   );

   // Update stage: swap the old entry out of the running sum
   assign new_sum = sum_cur - mavg_pkg::SUM_W'(old_smp) + mavg_pkg::SUM_W'(s1_ff.smp);
   // With a single channel the reported sum is the one just updated
   assign avg_src = (s1_ff.nxt_ch == s1_ff.ch) ? new_sum : sum_nxt;

   always_comb begin
      rsp_item.sampled_channel = mavg_pkg::OUT_CH_W'(s1_ff.ch);
      rsp_item.average_valid   = s1_ff.avg_ok;
      rsp_item.average_channel = s1_ff.avg_ok ? mavg_pkg::OUT_CH_W'(s1_ff.nxt_ch) : '0;
      rsp_item.average_value   = s1_ff.avg_ok ?
                                 avg_src[mavg_pkg::SL_W +: mavg_pkg::SAMPLE_W] : '0;
      rsp_item.capture_valid   = s1_ff.cap_valid;
      rsp_item.capture_slot    = s1_ff.cap_slot;
   end

   // Result queue
   mavg_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (rsp_item),
      .pop       (!rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (oq_data),
      .count     (oq_count)
   );

   assign rsp_sampled_channel = oq_data.sampled_channel;
   assign rsp_average_valid   = oq_data.average_valid;
   assign rsp_average_channel = oq_data.average_channel;
   assign rsp_average_value   = oq_data.average_value;
   assign rsp_capture_valid   = oq_data.capture_valid;
   assign rsp_capture_slot    = oq_data.capture_slot;

   // An accepted sample is in the update stage on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted sample did not reach update stage");

   // Channel and slot counters stay in range
   assert property (@(posedge clock) disable iff (reset)
      (ch_ff <= mavg_pkg::CH_LAST) && (sl_ff <= mavg_pkg::SL_LAST))
      else $error("channel or slot counter out of range");

   // Wrapping the last channel returns to channel zero
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && (ch_ff == mavg_pkg::CH_LAST) |=> (ch_ff == '0))
      else $error("channel did not wrap");

endmodule
